### rtl/wme_pkg.sv
`timescale 1ns / 1ps
package wme_pkg;
  localparam int unsigned MaxDim = 16;
  localparam int unsigned DimW = $clog2(MaxDim);
  localparam int unsigned AddrW = 2 * DimW;
  localparam int unsigned Depth = MaxDim * MaxDim;

  localparam logic [2:0] OpWrite = 3'd0;
  localparam logic [2:0] OpRead = 3'd1;
  localparam logic [2:0] OpLoadA = 3'd2;
  localparam logic [2:0] OpLoadB = 3'd3;
  localparam logic [2:0] OpMult = 3'd4;
  localparam logic [2:0] OpUpdate = 3'd5;

  localparam logic [1:0] RegRows = 2'd0;
  localparam logic [1:0] RegCols = 2'd1;
  localparam logic [1:0] RegRate = 2'd2;
  localparam logic [1:0] RegMom = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
  } result_t;

  function automatic logic [4:0] eff_dim(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MaxDim)) return 5'(MaxDim);
    return v;
  endfunction
endpackage

### rtl/wme_ram.sv
`timescale 1ns / 1ps
module wme_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/weight_matrix_engine.sv
`timescale 1ns / 1ps
// Weight matrix engine: a 16x16 signed Q8.8 matrix in a single-port-read RAM
// plus two 16-entry vector RAMs. After reset a clearing pass zeroes all 256
// matrix entries; no transaction is accepted meanwhile. Writes and loads
// complete on acceptance; a read passes through a read and an output state.
// Multiply walks count x len entries, one MAC per cycle, with a drain after
// each result until the pipeline is empty and the previous output is taken.
// Update walks rows x cols entries, one read-modify-write per cycle pipelined
// over 4 stages. The single matrix read port sets the pace of both walks.
module weight_matrix_engine import wme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], row_index[8:3], col_index[14:9], data_value[30:15],
  // vector_length[35:31], zeros
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_value[31:0], result_index[35:32], zeros
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StMult = 3'd3;
  localparam logic [2:0] StUpd = 3'd4;
  localparam logic [2:0] StOut = 3'd5;
  localparam logic [2:0] StDrain = 3'd6;

  logic [2:0] st_q, st_d;
  logic [4:0] rows_q, cols_q;
  logic [15:0] rate_q, mom_q;

  logic [2:0] op_q;
  logic [5:0] row_q, col_q;
  logic [4:0] len_q, cnt_q;
  logic       colsum_q;
  logic [4:0] k_q, i_q;
  logic [AddrW-1:0] clr_q;

  logic        w_we;
  logic [AddrW-1:0] w_waddr, w_raddr;
  logic [15:0] w_wdata, w_rdata;
  logic        a_we, b_we;
  logic [DimW-1:0] a_raddr, b_raddr;
  logic [15:0] a_rdata, b_rdata;

  // pipeline valid bits
  logic        p1_q, p2_q, p3_q;
  logic [AddrW-1:0] ad1_q, ad2_q, ad3_q;
  logic signed [31:0] prod_q;
  logic signed [47:0] acc_q;
  logic signed [47:0] t1_q, t2_q;
  logic signed [31:0] ab_q;
  logic signed [15:0] m2_q;

  result_t res_q;
  logic    ov_q;

  logic [4:0] rr, cc;
  logic [2:0] in_op;
  logic [5:0] in_row, in_col;
  logic [15:0] in_data;
  logic [4:0] in_len;

  assign rr = eff_dim(rows_q);
  assign cc = eff_dim(cols_q);
  assign in_op = s_axis_tdata[2:0];
  assign in_row = s_axis_tdata[8:3];
  assign in_col = s_axis_tdata[14:9];
  assign in_data = s_axis_tdata[30:15];
  assign in_len = s_axis_tdata[35:31];

  assign s_axis_tready = (st_q == StIdle) && !ov_q;
  assign cfg_ready_o = 1'b1;
  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  wme_ram #(.Width(16), .Depth(Depth)) u_w (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata));
  wme_ram #(.Width(16), .Depth(MaxDim)) u_a (
    .clk_i, .we_i(a_we), .waddr_i(in_row[DimW-1:0]), .wdata_i(in_data),
    .raddr_i(a_raddr), .rdata_o(a_rdata));
  wme_ram #(.Width(16), .Depth(MaxDim)) u_b (
    .clk_i, .we_i(b_we), .waddr_i(in_row[DimW-1:0]), .wdata_i(in_data),
    .raddr_i(b_raddr), .rdata_o(b_rdata));

  assign a_we = acc_in && in_op == OpLoadA && in_row < 6'(MaxDim);
  assign b_we = acc_in && in_op == OpLoadB && in_row < 6'(MaxDim);

  // issue stage
  logic issue;
  logic [AddrW-1:0] iss_addr;
  always_comb begin
    issue = 1'b0;
    iss_addr = '0;
    a_raddr = '0;
    b_raddr = '0;
    if (st_q == StRead) begin
      iss_addr = {row_q[DimW-1:0], col_q[DimW-1:0]};
    end else if (st_q == StMult) begin
      issue = (len_q != 5'd0);
      iss_addr = colsum_q ? {i_q[DimW-1:0], k_q[DimW-1:0]}
                          : {k_q[DimW-1:0], i_q[DimW-1:0]};
      a_raddr = i_q[DimW-1:0];
    end else if (st_q == StUpd) begin
      issue = 1'b1;
      iss_addr = {k_q[DimW-1:0], i_q[DimW-1:0]};
      a_raddr = k_q[DimW-1:0];
      b_raddr = i_q[DimW-1:0];
    end
  end
  assign w_raddr = iss_addr;

  // update arithmetic
  logic signed [47:0] tsum;
  logic signed [25:0] shr;
  logic signed [25:0] rnd;
  logic signed [15:0] sat16;
  assign tsum = t1_q + t2_q + 48'sd2097152;
  assign shr = tsum[47:22];
  assign rnd = shr > 26'sd32767 ? 26'sd32767 : shr < -26'sd32768 ? -26'sd32768 : shr;
  assign sat16 = rnd[15:0];

  always_comb begin
    w_we = 1'b0;
    w_waddr = ad3_q;
    w_wdata = sat16;
    if (st_q == StClear) begin
      w_we = 1'b1;
      w_waddr = clr_q;
      w_wdata = '0;
    end else if (acc_in && in_op == OpWrite && in_row < 6'(rr) && in_col < 6'(cc)) begin
      w_we = 1'b1;
      w_waddr = {in_row[DimW-1:0], in_col[DimW-1:0]};
      w_wdata = in_data;
    end else if (op_q == OpUpdate && p3_q) begin
      w_we = 1'b1;
    end
  end

  logic signed [47:0] accn;
  assign accn = acc_q + 48'(prod_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StClear: if (clr_q == AddrW'(Depth - 1)) st_d = StIdle;
      StIdle: if (acc_in) begin
        if (in_op == OpRead) st_d = StRead;
        else if (in_op == OpMult) st_d = StMult;
        else if (in_op == OpUpdate) st_d = StUpd;
      end
      StRead: st_d = StOut;
      StOut: st_d = StIdle;
      StMult: if (len_q == 5'd0 || i_q + 5'd1 == len_q) st_d = StDrain;
      StUpd: if (i_q + 5'd1 == cc && k_q + 5'd1 == rr) st_d = StDrain;
      StDrain: ;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
      rows_q <= 5'd16;
      cols_q <= 5'd16;
      rate_q <= '0;
      mom_q <= 16'd16384;
      p1_q <= 1'b0;
      p2_q <= 1'b0;
      p3_q <= 1'b0;
      ov_q <= 1'b0;
      op_q <= '0;
      k_q <= '0;
      i_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegRows: rows_q <= cfg_data_i[4:0];
          RegCols: cols_q <= cfg_data_i[4:0];
          RegRate: rate_q <= cfg_data_i;
          RegMom: mom_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      if (st_q == StClear) clr_q <= clr_q + AddrW'(1);
      p1_q <= issue;
      p2_q <= p1_q;
      p3_q <= p2_q;
      case (st_q)
        StIdle: if (acc_in) begin
          op_q <= in_op;
          k_q <= '0;
          i_q <= '0;
        end
        StOut: ov_q <= 1'b1;
        StMult: begin
          if (len_q == 5'd0 || i_q + 5'd1 == len_q) begin
            i_q <= '0;
          end else begin
            i_q <= i_q + 5'd1;
          end
        end
        StUpd: begin
          if (i_q + 5'd1 == cc) begin
            i_q <= '0;
            k_q <= k_q + 5'd1;
          end else begin
            i_q <= i_q + 5'd1;
          end
        end
        default: ;
      endcase
      if (st_q == StDrain) begin
        if (op_q == OpMult) begin
          if (!p3_q && !p2_q && !p1_q && !ov_q) begin
            ov_q <= 1'b1;
            k_q <= k_q + 5'd1;
            st_q <= (k_q + 5'd1 == cnt_q) ? StIdle : StMult;
          end
        end else if (!p3_q && !p2_q && !p1_q) begin
          st_q <= StIdle;
        end
      end else begin
        st_q <= st_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      row_q <= in_row;
      col_q <= in_col;
      colsum_q <= (in_len == rr);
      cnt_q <= (in_len == rr) ? cc : rr;
      len_q <= (in_len == rr) ? rr : ((in_len < cc) ? in_len : cc);
    end
    if (st_q == StMult && i_q == 5'd0) acc_q <= '0;
    ad1_q <= iss_addr;
    ad2_q <= ad1_q;
    ad3_q <= ad2_q;
    // stage 2: products
    prod_q <= $signed(a_rdata) * $signed(w_rdata);
    ab_q <= $signed(a_rdata) * $signed(b_rdata);
    m2_q <= $signed(w_rdata);
    // stage 3
    if (op_q == OpMult && p2_q) begin
      acc_q <= accn;
    end
    t1_q <= 48'($signed(m2_q) * $signed({1'b0, mom_q})) <<< 8;
    t2_q <= 48'($signed(ab_q) * $signed({1'b0, rate_q}));
    if (st_q == StOut) begin
      res_q.value <= (row_q < 6'(rr) && col_q < 6'(cc)) ? 32'($signed(w_rdata)) : '0;
      res_q.index <= '0;
      res_q.last <= 1'b1;
    end
    if (st_q == StDrain && op_q == OpMult && !p3_q && !p2_q && !p1_q && !ov_q) begin
      res_q.value <= 32'(acc_q > 48'sh7FFFFFFF ? 48'sh7FFFFFFF :
                         acc_q < -48'sh80000000 ? -48'sh80000000 : acc_q);
      res_q.index <= k_q[3:0];
      res_q.last <= (k_q + 5'd1 == cnt_q);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {4'd0, res_q.index, res_q.value};
  assign m_axis_tlast = res_q.last;

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StClear |-> !s_axis_tready) else $error("accept during clear");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  a_no_write_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StMult |-> !w_we) else $error("matrix write during multiply");
endmodule
